// ----- rtl/ssdisp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssdisp_pkg: shared types and constants of the seven-segment display driver
// Command codes, field widths, glyph table and divide-by-constant factors.
// ----------------------------------------------------------------------------
package ssdisp_pkg;

	localparam int NUM_DIGITS = 4;
	localparam int POS_W      = 2;
	localparam int VALUE_W    = 16;
	localparam int SEG_W      = 8;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

	typedef enum logic {
		CMD_SET  = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef logic [SEG_W-1:0] seg_t;

	// Segment bit that lights the decimal point.
	localparam int POINT_BIT = 6;
	localparam seg_t GLYPH_ZERO = 8'hBE;
	localparam seg_t SEG_BLANK  = 8'h00;

	// Reciprocal factors: q = (mag * M) >> K is exact for every magnitude up to 32768.
	localparam logic [15:0] RECIP_10   = 16'd52429;  // K = 19
	localparam logic [12:0] RECIP_100  = 13'd5243;   // K = 19
	localparam logic [15:0] RECIP_1000 = 16'd33555;  // K = 25

	function automatic seg_t glyph(input logic [3:0] digit);
		seg_t pat;
		case (digit)
			4'd0:    pat = 8'hBE;
			4'd1:    pat = 8'h82;
			4'd2:    pat = 8'h37;
			4'd3:    pat = 8'hA7;
			4'd4:    pat = 8'h8B;
			4'd5:    pat = 8'hAD;
			4'd6:    pat = 8'hBD;
			4'd7:    pat = 8'h86;
			4'd8:    pat = 8'hBF;
			4'd9:    pat = 8'hAF;
			default: pat = SEG_BLANK;
		endcase
		return pat;
	endfunction

endpackage

// ----- rtl/seven_segment_mux_display_driver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_mux_display_driver: four-digit multiplexed display driver
// Converts a signed value to blank-suppressed decimal glyphs and scans them.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while no tick waits on a stalled
// output. A set item (tuser low) latches new glyphs for the four positions and
// returns nothing; a tick item (tuser high) returns the glyph and the
// active-low enable of the current scan position and advances the scan. Items
// pass an input register and a quotient register (three reciprocal multipliers
// for /10, /100, /1000), and the result register drives the output.
// Items stay in order, so a tick always sees every earlier set.
module seven_segment_mux_display_driver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [15:0] value, [19:16] decimal_points, [23:20] zero
	input  logic [ssdisp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] command
	input  logic                               s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [7:0] segments, [11:8] digit_enable_n, [15:12] zero
	output logic [ssdisp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import ssdisp_pkg::*;

	// Input stage.
	logic                  valid_s1;
	cmd_t                  cmd_s1;
	logic [VALUE_W-1:0]    value_s1;
	logic [NUM_DIGITS-1:0] dp_s1;

	// Quotient stage.
	logic                  valid_s2;
	cmd_t                  cmd_s2;
	logic                  neg_s2;
	logic [NUM_DIGITS-1:0] dp_s2;
	logic [VALUE_W-1:0]    mag_s2;
	logic [11:0]           q1_s2;
	logic [8:0]            q2_s2;
	logic [5:0]            q3_s2;

	seg_t                  patterns_q [NUM_DIGITS];
	logic [POS_W-1:0]      scan_q;
	logic                  out_valid_q;
	seg_t                  seg_q;
	logic [NUM_DIGITS-1:0] den_q;

	logic                  out_free;
	logic                  adv1;
	logic                  adv2;
	logic                  tick_go;

	logic                  neg;
	logic [VALUE_W-1:0]    mag;
	logic [31:0]           prod1;
	logic [28:0]           prod2;
	logic [31:0]           prod3;

	logic [3:0]            d0;
	logic [3:0]            d1;
	logic [3:0]            d2;
	logic [3:0]            d3;
	logic [VALUE_W-1:0]    rem0;
	logic [11:0]           rem1;
	logic [8:0]            rem2;
	seg_t                  new_pat [NUM_DIGITS];

	assign out_free      = !out_valid_q || m_axis_tready;
	assign tick_go       = valid_s2 && (cmd_s2 == CMD_TICK);
	assign adv2          = !valid_s2 || (cmd_s2 == CMD_SET) || out_free;
	assign adv1          = !valid_s1 || adv2;
	assign s_axis_tready = adv1;

	// Magnitude and quotients from the input register.
	assign neg   = value_s1[VALUE_W-1];
	assign mag   = neg ? (~value_s1 + 16'd1) : value_s1;
	assign prod1 = 32'(mag) * 32'(RECIP_10);
	assign prod2 = 29'(mag) * 29'(RECIP_100);
	assign prod3 = 32'(mag) * 32'(RECIP_1000);

	// Digits from the quotient register; each is below ten, so four bits hold it.
	assign rem0 = mag_s2 - 16'(q1_s2) * 16'd10;
	assign rem1 = q1_s2 - 12'(q2_s2) * 12'd10;
	assign rem2 = q2_s2 - 9'(q3_s2) * 9'd10;
	assign d0   = rem0[3:0];
	assign d1   = rem1[3:0];
	assign d2   = rem2[3:0];

	always_comb begin
		if (q3_s2 >= 6'd30) begin
			d3 = 4'(q3_s2 - 6'd30);
		end else if (q3_s2 >= 6'd20) begin
			d3 = 4'(q3_s2 - 6'd20);
		end else if (q3_s2 >= 6'd10) begin
			d3 = 4'(q3_s2 - 6'd10);
		end else begin
			d3 = q3_s2[3:0];
		end
	end

	// Higher positions go blank once the remaining quotient is zero.
	always_comb begin
		new_pat[3] = glyph(d0);
		new_pat[2] = (q1_s2 != 12'd0) ? glyph(d1) : SEG_BLANK;
		new_pat[1] = (q2_s2 != 9'd0) ? glyph(d2) : SEG_BLANK;
		new_pat[0] = (q3_s2 != 6'd0) ? glyph(d3) : SEG_BLANK;
		new_pat[3][POINT_BIT] = neg_s2 || dp_s2[3];
		new_pat[2][POINT_BIT] = dp_s2[2];
		new_pat[1][POINT_BIT] = dp_s2[1];
		new_pat[0][POINT_BIT] = dp_s2[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_axis_tvalid) begin
			cmd_s1   <= cmd_t'(s_axis_tuser);
			value_s1 <= s_axis_tdata[VALUE_W-1:0];
			dp_s1    <= s_axis_tdata[VALUE_W +: NUM_DIGITS];
		end
		if (adv2 && valid_s1) begin
			cmd_s2 <= cmd_s1;
			neg_s2 <= neg;
			dp_s2  <= dp_s1;
			mag_s2 <= mag;
			q1_s2  <= prod1[30:19];
			q2_s2  <= prod2[27:19];
			q3_s2  <= prod3[30:25];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				patterns_q[i] <= GLYPH_ZERO;
			end
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_s2 && (cmd_s2 == CMD_SET)) begin
				for (int i = 0; i < NUM_DIGITS; i++) begin
					patterns_q[i] <= new_pat[i];
				end
			end
			if (out_free) begin
				out_valid_q <= tick_go;
				if (tick_go) begin
					scan_q <= scan_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && tick_go) begin
			seg_q <= patterns_q[scan_q];
			den_q <= ~(4'b0001 << scan_q);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, den_q, seg_q};

`ifndef SYNTH
	a_tick_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_free && tick_go) |=> (den_q == ~(4'b0001 << $past(scan_q))))
		else $error("digit enable does not match the scan position");

	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($countones(den_q) == 3))
		else $error("more or fewer than one digit enabled");

	a_set_holds_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (cmd_s2 == CMD_SET)) |=> $stable(scan_q))
		else $error("set item moved the scan position");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the seven-segment display driver
// Feeds set and tick items over the input stream and checks every tick result
// against typed expectations or a behavioral model of the latched glyphs and scan.
// ----------------------------------------------------------------------------
module tb;
	import ssdisp_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int PLAN_ROWS    = 25;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		seg_t       segments;
		logic [3:0] digit_enable_n;
	} shown_t;

	// Directed row: the expected display is typed in only where typed is set.
	typedef struct packed {
		cmd_t        cmd;
		logic [15:0] value;
		logic [3:0]  points;
		logic        typed;
		seg_t        segments;
		logic [3:0]  digit_enable_n;
	} plan_row_t;

	localparam seg_t DIGIT_SHAPES [10] = '{
		8'hBE, 8'h82, 8'h37, 8'hA7, 8'h8B, 8'hAD, 8'hBD, 8'h86, 8'hBF, 8'hAF
	};

	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// Every position shows zero after reset; the fifth tick checks the wrap.
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'hBE, 4'b1110},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'hBE, 4'b1101},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'hBE, 4'b1011},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'hBE, 4'b0111},
		// Zero blanks the three upper positions.
		'{CMD_SET,  16'h0000, 4'h0, 1'b0, 8'h00, 4'b0000},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'h00, 4'b1110},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'h00, 4'b1101},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'h00, 4'b1011},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'hBE, 4'b0111},
		// The most negative value reads 2768 with the rightmost point lit.
		'{CMD_SET,  16'h8000, 4'h0, 1'b0, 8'h00, 4'b0000},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'h37, 4'b1110},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'h86, 4'b1101},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'hBD, 4'b1011},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b1, 8'hFF, 4'b0111},
		'{CMD_SET,  16'h7FFF, 4'hF, 1'b0, 8'h00, 4'b0000},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b0, 8'h00, 4'b0000},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b0, 8'h00, 4'b0000},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b0, 8'h00, 4'b0000},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b0, 8'h00, 4'b0000},
		'{CMD_SET,  16'hFFFF, 4'hA, 1'b0, 8'h00, 4'b0000},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b0, 8'h00, 4'b0000},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b0, 8'h00, 4'b0000},
		'{CMD_SET,  16'h0064, 4'h1, 1'b0, 8'h00, 4'b0000},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b0, 8'h00, 4'b0000},
		'{CMD_TICK, 16'h0000, 4'h0, 1'b0, 8'h00, 4'b0000}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	seg_t       model_glyphs [NUM_DIGITS];
	logic [1:0] model_scan;
	shown_t     shown_q [$];
	int         errors;
	int         cycles;
	bit         steady;
	bit         hold_req;
	bit         hold_done;

	seven_segment_mux_display_driver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Converts the magnitude to decimal and latches one glyph per position.
	function automatic void latch_value(input logic signed [15:0] value,
			input logic [3:0] points);
		int unsigned mag;
		int          pos;
		seg_t        pat [NUM_DIGITS];
		mag = (value < 0) ? int'(-int'(value)) : int'(value);
		for (pos = 0; pos < NUM_DIGITS; pos++)
			pat[pos] = SEG_BLANK;
		pat[3] = DIGIT_SHAPES[mag % 10];
		mag = mag / 10;
		for (pos = 2; pos >= 0; pos--) begin
			if (mag != 0) begin
				pat[pos] = DIGIT_SHAPES[mag % 10];
				mag = mag / 10;
			end
		end
		if (value < 0)
			pat[3][POINT_BIT] = 1'b1;
		for (pos = 0; pos < NUM_DIGITS; pos++) begin
			if (points[pos])
				pat[pos][POINT_BIT] = 1'b1;
			model_glyphs[pos] = pat[pos];
		end
	endfunction

	function automatic shown_t scan_output();
		shown_t r;
		r.segments       = model_glyphs[model_scan];
		r.digit_enable_n = ~(4'b0001 << model_scan);
		model_scan       = model_scan + 2'd1;
		return r;
	endfunction

	function automatic logic [15:0] pick_value();
		logic [15:0] mag;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 16'($urandom);
			4, 5, 6:    mag = 16'($urandom_range(0, 9999));
			7:          mag = 16'($urandom_range(0, 99));
			default: begin
				case ($urandom_range(0, 5))
					0:       return 16'h8000;
					1:       return 16'h7FFF;
					2:       return 16'hFFFF;
					3:       return 16'h0000;
					4:       return 16'd10000;
					default: return -16'sd10000;
				endcase
			end
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// Offers one item, waits for it to be taken, then updates the model.
	task automatic send_item(input cmd_t cmd, input logic [15:0] value,
			input logic [3:0] points, input logic typed, input shown_t typed_out);
		shown_t r;
		while (!steady && $urandom_range(0, 99) < 19) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, points, value};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (cmd == CMD_TICK) begin
			r = scan_output();
			shown_q.push_back(typed ? typed_out : r);
		end else begin
			latch_value(value, points);
		end
	endtask

	initial begin
		int i;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		errors     = 0;
		steady     = 1'b0;
		hold_req   = 1'b0;
		model_scan = 2'd0;
		for (i = 0; i < NUM_DIGITS; i++)
			model_glyphs[i] = 8'hBE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PLAN_ROWS; i++)
			send_item(PLAN[i].cmd, PLAN[i].value, PLAN[i].points, PLAN[i].typed,
				'{PLAN[i].segments, PLAN[i].digit_enable_n});

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			hold_req = hold_req || (i == 250);
			steady   = (i >= 500 && i < 650);
			if ($urandom_range(0, 99) < 55)
				send_item(CMD_TICK, 16'($urandom), 4'($urandom), 1'b0, '0);
			else
				send_item(CMD_SET, pick_value(), 4'($urandom), 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;

		while (shown_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Output side: random back-pressure, one long hold-off to fill the block.
	initial begin
		m_axis_tready <= 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				m_axis_tready <= steady || ($urandom_range(0, 99) >= 19);
			end
		end
	end

	always @(posedge clk) begin : check_results
		shown_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (shown_q.size() == 0) begin
				$error("unexpected item: tdata %h", m_axis_tdata);
				errors++;
			end else begin
				want = shown_q.pop_front();
				if (m_axis_tdata[7:0] !== want.segments) begin
					$error("segments: expected %h, actual %h", want.segments,
						m_axis_tdata[7:0]);
					errors++;
				end
				if (m_axis_tdata[11:8] !== want.digit_enable_n) begin
					$error("digit_enable_n: expected %b, actual %b",
						want.digit_enable_n, m_axis_tdata[11:8]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= (cycles === 'x) ? 1 : cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule

// ----- seven_segment_mux_display_driver.f -----
rtl/ssdisp_pkg.sv
rtl/seven_segment_mux_display_driver.sv
sim/tb.sv
